/* src/edt_pkg.sv */
`timescale 1ns / 1ps

package edt_pkg;

  localparam int CHANNELS     = 4;
  localparam int SAMPLE_BITS  = 10;
  localparam int FRAC_BITS    = 16;
  localparam int VAL_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int CH_BITS      = 2;
  localparam int MODE_BITS    = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int ALPHA_BITS   = 17;
  localparam int THR_BITS     = VAL_BITS;
  localparam int INIT_BITS    = 16;
  localparam int CFG_BITS     = VAL_BITS;
  localparam int PROD_BITS    = ALPHA_BITS + VAL_BITS;
  localparam int STEP_BITS    = PROD_BITS - FRAC_BITS;
  localparam int DVD_BITS     = VAL_BITS + FRAC_BITS;
  localparam int DVS_BITS     = INIT_BITS;
  localparam int DIV_CNT_BITS = $clog2(DVD_BITS);

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = ALPHA_BITS'(65536);
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(6554);
  localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(3276800);
  localparam logic [INIT_BITS-1:0]  INIT_RESET  = INIT_BITS'(64);
  localparam logic [PROD_BITS-1:0]  ROUND_HALF  = PROD_BITS'(32768);
  localparam logic [VAL_BITS-1:0]   VAL_MAX     = '1;
  localparam logic [CH_BITS-1:0]    CH_LAST     = CH_BITS'(CHANNELS - 1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THR   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT  = 2'd2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_CAL    = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef struct packed {
    logic                start;
    logic [DVD_BITS-1:0] dividend;
    logic [DVS_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DVD_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

/* src/edt_div.sv */
`timescale 1ns / 1ps

module edt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  edt_pkg::div_req_t req_i,
  output edt_pkg::div_rsp_t rsp_o
);
  import edt_pkg::*;

  logic                    busy_q, done_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [DVD_BITS-1:0]     work_q;
  logic [DVS_BITS-1:0]     dvs_q, rem_q;
  logic [DVS_BITS:0]       rem_sh, rem_sub;
  logic                    fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_q, work_q[DVD_BITS-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_BITS'(DVD_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= req_i.dividend;
      dvs_q  <= req_i.divisor;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? rem_sub[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
      work_q <= {work_q[DVD_BITS-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = work_q;

endmodule

/* src/ema_deviation_trigger_unit.sv */
`timescale 1ns / 1ps

// Moving-average deviation trigger for four multiplexed converter channels. One word is
// taken at a time: a sample outside calibration steps through distance, multiply,
// update, deviation compare and output load; a start-calibration, clear or calibration
// sample goes to output load directly or after its sum update. The channel-3 sample
// that ends calibration runs the shared restoring divider once per channel, so that
// word waits for every channel's division. The result waits in an output register; the next
// word is taken once the previous result has been loaded there.
module ema_deviation_trigger_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [edt_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [edt_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [edt_pkg::MODE_BITS-1:0]       mode_i,
  input  logic [edt_pkg::CH_BITS-1:0]         channel_i,
  input  logic [edt_pkg::SAMPLE_BITS-1:0]     sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [edt_pkg::CH_BITS-1:0]         out_channel_o,
  output logic [edt_pkg::VAL_BITS-1:0]        deviation_o,
  output logic                                triggered_o,
  output logic                                calibrating_o
);
  import edt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CAL    = 9'b000000010,
    S_MAG    = 9'b000000100,
    S_MUL    = 9'b000001000,
    S_UPD    = 9'b000010000,
    S_DEV    = 9'b000100000,
    S_DSTART = 9'b001000000,
    S_DWAIT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [ALPHA_BITS-1:0] alpha_q;
  logic [THR_BITS-1:0]   thr_q;
  logic [INIT_BITS-1:0]  init_q;

  logic [VAL_BITS-1:0]   avg_q [CHANNELS];
  logic [VAL_BITS-1:0]   cl_q  [CHANNELS];
  logic [VAL_BITS-1:0]   sum_q [CHANNELS];
  logic [INIT_BITS-1:0]  rounds_q;
  logic                  flag_q;

  logic [CH_BITS-1:0]     ch_q;
  logic [SAMPLE_BITS-1:0] x_q;
  logic                   ge_q;
  logic [VAL_BITS-1:0]    mag_q, dev_q;
  logic [PROD_BITS-1:0]   prod_q;

  logic                   out_valid_q;
  logic [CH_BITS-1:0]     out_ch_q;
  logic [VAL_BITS-1:0]    out_dev_q;
  logic                   out_trig_q, out_cal_q;

  logic                   acc, ch_ok, out_free;
  logic [VAL_BITS-1:0]    avg_rd, cl_rd, sum_rd, xq, dev_c, avg_new;
  logic [ALPHA_BITS-1:0]  a_eff;
  logic [PROD_BITS-1:0]   prod_d, prod_rnd;
  logic [STEP_BITS-1:0]   step;
  logic [VAL_BITS:0]      avg_wide, sum_wide;
  logic [DVS_BITS-1:0]    n_eff;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign in_ready_o = state_q == S_IDLE;
  assign acc        = in_valid_i && in_ready_o;
  assign ch_ok      = 32'(channel_i) < CHANNELS;
  assign out_free   = !out_valid_q || out_ready_i;

  // ch_q indexes every per-channel read; the divider loop reuses it and ends on the
  // last channel, which is also the channel of the word that ended calibration
  assign avg_rd = avg_q[ch_q];
  assign cl_rd  = cl_q[ch_q];
  assign sum_rd = sum_q[ch_q];
  assign xq     = {x_q, FRAC_BITS'(0)};

  assign a_eff    = alpha_q[ALPHA_BITS-1] ? ALPHA_ONE : alpha_q;
  assign prod_d   = a_eff * mag_q;
  assign prod_rnd = prod_q + ROUND_HALF;
  assign step     = prod_rnd[PROD_BITS-1:FRAC_BITS];
  assign avg_wide = ge_q ? {1'b0, avg_rd} + step : {1'b0, avg_rd} - step;
  assign avg_new  = avg_wide[VAL_BITS-1:0];
  assign dev_c    = avg_rd > cl_rd ? avg_rd - cl_rd : cl_rd - avg_rd;
  assign sum_wide = {1'b0, sum_rd} + (VAL_BITS + 1)'(x_q);

  assign n_eff            = (init_q == '0) ? DVS_BITS'(1) : init_q;
  assign div_req.start    = state_q == S_DSTART;
  assign div_req.divisor  = n_eff;
  assign div_req.dividend = {sum_rd, FRAC_BITS'(0)} + DVD_BITS'(n_eff >> 1);

  edt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (mode_i == MODE_SAMPLE && ch_ok) begin
            state_d = (rounds_q == '0) ? S_MAG : S_CAL;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_CAL: begin
        if (ch_q == CH_LAST && rounds_q == INIT_BITS'(1)) begin
          state_d = S_DSTART;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MAG:    state_d = S_MUL;
      S_MUL:    state_d = S_UPD;
      S_UPD:    state_d = S_DEV;
      S_DEV:    state_d = S_OUT;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_rsp.done) begin
          state_d = (ch_q == CH_LAST) ? S_OUT : S_DSTART;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alpha_q     <= ALPHA_RESET;
      thr_q       <= THR_RESET;
      init_q      <= INIT_RESET;
      rounds_q    <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        avg_q[i] <= '0;
        cl_q[i]  <= '0;
        sum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ALPHA: alpha_q <= cfg_wdata_i[ALPHA_BITS-1:0];
          CFG_THR:   thr_q   <= cfg_wdata_i[THR_BITS-1:0];
          CFG_INIT:  init_q  <= cfg_wdata_i[INIT_BITS-1:0];
          default: ;
        endcase
      end
      if (acc && mode_i == MODE_CAL) begin
        rounds_q <= init_q;
        for (int i = 0; i < CHANNELS; i++) begin
          cl_q[i]  <= '0;
          sum_q[i] <= '0;
        end
      end
      if (acc && mode_i == MODE_CLEAR) begin
        flag_q <= 1'b0;
      end
      if (state_q == S_CAL) begin
        // saturating per-channel sum
        sum_q[ch_q] <= sum_wide[VAL_BITS] ? VAL_MAX : sum_wide[VAL_BITS-1:0];
        if (ch_q == CH_LAST) begin
          rounds_q <= rounds_q - 1'b1;
        end
      end
      if (state_q == S_UPD) begin
        avg_q[ch_q] <= avg_new;
      end
      if (state_q == S_DEV && dev_c > thr_q) begin
        flag_q <= 1'b1;
      end
      if (state_q == S_DWAIT && div_rsp.done) begin
        cl_q[ch_q] <= (div_rsp.quotient[DVD_BITS-1:VAL_BITS] != '0) ? VAL_MAX
                                                                    : div_rsp.quotient[VAL_BITS-1:0];
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ch_q  <= channel_i;
      x_q   <= sample_i;
      dev_q <= '0;
    end
    // ch_q goes to zero for the divider loop only when the last channel ended calibration
    if (state_q == S_CAL && ch_q == CH_LAST && rounds_q == INIT_BITS'(1)) begin
      ch_q <= '0;
    end
    if (state_q == S_DWAIT && div_rsp.done && ch_q != CH_LAST) begin
      ch_q <= ch_q + 1'b1;
    end
    if (state_q == S_MAG) begin
      ge_q  <= xq >= avg_rd;
      mag_q <= (xq >= avg_rd) ? xq - avg_rd : avg_rd - xq;
    end
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == S_DEV) begin
      dev_q <= dev_c;
    end
    if (state_q == S_OUT && out_free) begin
      out_ch_q   <= ch_q;
      out_dev_q  <= dev_q;
      out_trig_q <= flag_q;
      out_cal_q  <= rounds_q != '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign deviation_o   = out_dev_q;
  assign triggered_o   = out_trig_q;
  assign calibrating_o = out_cal_q;

  a_dev_only_free_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && deviation_o != '0 |-> !calibrating_o)
    else $error("nonzero deviation reported during calibration");

  a_clear_drops_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && mode_i == MODE_CLEAR |=> !flag_q)
    else $error("trigger flag survived a clear word");

  a_cal_loads_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && mode_i == MODE_CAL |=> rounds_q == $past(init_q))
    else $error("round counter not loaded on calibration start");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DWAIT)
    else $error("divider finished outside its wait state");

  a_div_only_after_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DSTART |-> rounds_q == '0)
    else $error("centerline division started with rounds remaining");

endmodule
